// ===== rtl/core/raster_row_shear_with_fill_assert.svh =====
// ---------------------------------------------------------------------------
// raster_row_shear_with_fill assertion macros
// Shared concurrent assertion forms, sampled on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RASTER_ROW_SHEAR_WITH_FILL_ASSERT_SVH
`define RASTER_ROW_SHEAR_WITH_FILL_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RRSF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RRSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rrsf_pkg.sv =====
// ---------------------------------------------------------------------------
// rrsf_pkg
// Types, constants and helpers shared by the row shear blocks.
// ---------------------------------------------------------------------------
package rrsf_pkg;

  localparam int DIM_W      = 13;
  localparam int COL_W      = 12;
  localparam int DIV_W      = 14;
  localparam int DIV_CNT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;

  localparam logic [DIM_W-1:0] MAX_DIM   = 13'd4096;
  localparam logic [7:0]       FILL_BYTE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SHIFT  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_FILL  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_PAD   = 2'd2
  } kind_t;

  typedef enum logic {
    FS_RUN = 1'b0,
    FS_DIV = 1'b1
  } front_state_t;

  typedef enum logic [1:0] {
    PH_LEFT  = 2'd0,
    PH_PIXEL = 2'd1,
    PH_RIGHT = 2'd2,
    PH_PAD   = 2'd3
  } back_phase_t;

  // one classified input pixel, waiting to be expanded into results
  typedef struct packed {
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [DIM_W-1:0] left_len;
    logic [DIM_W-1:0] right_len;
    logic [1:0]       pad_len;
    logic             row_last;
  } cmd_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [DIM_W-1:0] run_length;
    logic             row_end;
    logic             last;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIM_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = {{(DIM_W-1){1'b0}}, 1'b1};
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rrsf_div.sv =====
// ---------------------------------------------------------------------------
// rrsf_div
// Restoring divider, one quotient bit per cycle, for the row shift step.
// ---------------------------------------------------------------------------
module rrsf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rrsf_pkg::div_req_t req_i,
  output rrsf_pkg::div_rsp_t rsp_o
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [rrsf_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rrsf_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [rrsf_pkg::DIM_W-1:0]     acc_r, acc_nxt;
  logic [rrsf_pkg::DIM_W-1:0]     dvs_r, dvs_nxt;
  logic [rrsf_pkg::DIV_W-1:0]     trial;
  logic [rrsf_pkg::DIV_W-1:0]     diff;
  logic                           fits;

  always_comb begin
    trial = {acc_r, quo_r[rrsf_pkg::DIV_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = trial >= {1'b0, dvs_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    acc_nxt  = acc_r;
    dvs_nxt  = dvs_r;
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req_i.dividend;
      acc_nxt  = '0;
      dvs_nxt  = req_i.divisor;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so it fits DIM_W bits
      acc_nxt = fits ? diff[rrsf_pkg::DIM_W-1:0] : trial[rrsf_pkg::DIM_W-1:0];
      quo_nxt = {quo_r[rrsf_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rrsf_pkg::DIV_CNT_W'(rrsf_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    acc_r <= acc_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp_o.done      = done_r;
  assign rsp_o.quotient  = quo_r;
  assign rsp_o.remainder = acc_r;

endmodule

// ===== rtl/core/rrsf_front.sv =====
// ---------------------------------------------------------------------------
// rrsf_front
// Configuration registers, row tracking and classification of each pixel.
// ---------------------------------------------------------------------------
`include "raster_row_shear_with_fill_assert.svh"

module rrsf_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [7:0]                     blue_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     red_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rrsf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rrsf_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output rrsf_pkg::cmd_t                 q_cmd_o,
  output rrsf_pkg::div_req_t             div_req_o,
  input  rrsf_pkg::div_rsp_t             div_rsp_i
);

  rrsf_pkg::front_state_t state_r, state_nxt;

  logic [rrsf_pkg::DIM_W-1:0] width_r, width_nxt;
  logic [rrsf_pkg::DIM_W-1:0] height_r, height_nxt;
  logic [rrsf_pkg::DIM_W-1:0] shift_r, shift_nxt;
  logic [rrsf_pkg::COL_W-1:0] col_r, col_nxt;
  logic [rrsf_pkg::DIM_W-1:0] left_fill_r, left_fill_nxt;
  logic [rrsf_pkg::DIM_W-1:0] shift_rem_r, shift_rem_nxt;
  logic [rrsf_pkg::DIM_W-1:0] left_hold_r, left_hold_nxt;
  logic [rrsf_pkg::DIM_W-1:0] shift_hold_r, shift_hold_nxt;

  logic [rrsf_pkg::DIM_W-1:0] w_eff;
  logic [rrsf_pkg::DIM_W-1:0] h_eff;
  logic [rrsf_pkg::DIM_W-1:0] left;
  logic [rrsf_pkg::DIM_W-1:0] col_inc;
  logic                       row_last;
  logic                       accept;
  logic                       cfg_wr;
  logic [rrsf_pkg::DIM_W+1:0] fill_sum;
  logic [rrsf_pkg::DIM_W-1:0] fill_new;

  always_comb begin
    w_eff    = rrsf_pkg::clamp_dim(width_r);
    h_eff    = rrsf_pkg::clamp_dim(height_r);
    left     = (left_fill_r < shift_r) ? left_fill_r : shift_r;
    col_inc  = {1'b0, col_r} + 1'b1;
    row_last = col_inc >= w_eff;
    accept   = push_i && !full_o;
    cfg_wr   = cfg_valid_i && cfg_ready_o;
    fill_sum = {2'b00, left_hold_r} + {1'b0, div_rsp_i.quotient};
    fill_new = (fill_sum > {2'b00, shift_hold_r}) ? shift_hold_r
                                                  : fill_sum[rrsf_pkg::DIM_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrsf_pkg::FS_RUN: begin
        if (accept && row_last) begin
          state_nxt = rrsf_pkg::FS_DIV;
        end
      end
      rrsf_pkg::FS_DIV: begin
        if (div_rsp_i.done) begin
          state_nxt = rrsf_pkg::FS_RUN;
        end
      end
      default: state_nxt = rrsf_pkg::FS_RUN;
    endcase
  end

  // outputs
  always_comb begin
    full_o      = (state_r != rrsf_pkg::FS_RUN) || q_full_i;
    cfg_ready_o = (state_r == rrsf_pkg::FS_RUN);
    q_push_o    = accept;

    q_cmd_o.blue      = blue_i;
    q_cmd_o.green     = green_i;
    q_cmd_o.red       = red_i;
    q_cmd_o.left_len  = (col_r == '0) ? left : '0;
    q_cmd_o.right_len = row_last ? (shift_r - left) : '0;
    // (w + s) pixels of 3 bytes need exactly (w + s) mod 4 pad bytes
    q_cmd_o.pad_len   = row_last ? (w_eff[1:0] + shift_r[1:0]) : 2'b00;
    q_cmd_o.row_last  = row_last;

    div_req_o.start    = accept && row_last;
    div_req_o.dividend = {1'b0, shift_rem_r} + {1'b0, shift_r};
    div_req_o.divisor  = h_eff;
  end

  // row and configuration state
  always_comb begin
    width_nxt      = width_r;
    height_nxt     = height_r;
    shift_nxt      = shift_r;
    col_nxt        = col_r;
    left_fill_nxt  = left_fill_r;
    shift_rem_nxt  = shift_rem_r;
    left_hold_nxt  = left_hold_r;
    shift_hold_nxt = shift_hold_r;

    if (cfg_wr) begin
      case (cfg_index_i)
        rrsf_pkg::CFG_WIDTH:  width_nxt  = cfg_data_i;
        rrsf_pkg::CFG_HEIGHT: height_nxt = cfg_data_i;
        rrsf_pkg::CFG_SHIFT:  shift_nxt  = cfg_data_i;
        default: ;
      endcase
    end

    if (accept) begin
      if (row_last) begin
        col_nxt        = '0;
        left_hold_nxt  = left;
        shift_hold_nxt = shift_r;
      end else begin
        col_nxt = col_inc[rrsf_pkg::COL_W-1:0];
      end
    end

    if (state_r == rrsf_pkg::FS_DIV && div_rsp_i.done) begin
      left_fill_nxt = fill_new;
      shift_rem_nxt = div_rsp_i.remainder;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrsf_pkg::FS_RUN;
      width_r     <= {{(rrsf_pkg::DIM_W-1){1'b0}}, 1'b1};
      height_r    <= {{(rrsf_pkg::DIM_W-1){1'b0}}, 1'b1};
      shift_r     <= '0;
      col_r       <= '0;
      left_fill_r <= '0;
      shift_rem_r <= '0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      shift_r     <= shift_nxt;
      col_r       <= col_nxt;
      left_fill_r <= left_fill_nxt;
      shift_rem_r <= shift_rem_nxt;
    end
    left_hold_r  <= left_hold_nxt;
    shift_hold_r <= shift_hold_nxt;
  end

  `RRSF_ASSERT_SAME(a_div_blocks_input, state_r == rrsf_pkg::FS_DIV, full_o, "input open during shift division")
  `RRSF_ASSERT_NEXT(a_row_end_divides, accept && row_last, state_r == rrsf_pkg::FS_DIV, "row end did not start division")
  `RRSF_ASSERT_SAME(a_done_when_waiting, div_rsp_i.done, state_r == rrsf_pkg::FS_DIV, "division result with no row pending")

endmodule

// ===== rtl/core/rrsf_cmd_q.sv =====
// ---------------------------------------------------------------------------
// rrsf_cmd_q
// Short register queue of classified pixels between front and back.
// ---------------------------------------------------------------------------
`include "raster_row_shear_with_fill_assert.svh"

module rrsf_cmd_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  rrsf_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output rrsf_pkg::cmd_t head_o,
  output logic           empty_o
);

  rrsf_pkg::cmd_t mem_r [rrsf_pkg::CMDQ_DEPTH];

  logic [rrsf_pkg::CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rrsf_pkg::CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rrsf_pkg::CMDQ_AW:0]   count_r, count_nxt;

  always_comb begin
    full_o     = (count_r == (rrsf_pkg::CMDQ_AW+1)'(rrsf_pkg::CMDQ_DEPTH));
    empty_o    = (count_r == '0);
    head_o     = mem_r[rd_ptr_r];
    wr_ptr_nxt = push_i ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_i ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push_i) begin
      mem_r[wr_ptr_r] <= cmd_i;
    end
  end

  `RRSF_ASSERT_SAME(a_no_overflow, push_i, !full_o, "push into full command queue")
  `RRSF_ASSERT_SAME(a_no_underflow, pop_i, !empty_o, "pop from empty command queue")

endmodule

// ===== rtl/core/rrsf_back.sv =====
// ---------------------------------------------------------------------------
// rrsf_back
// Expands each classified pixel into fill, pixel and padding results.
// ---------------------------------------------------------------------------
module rrsf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rrsf_pkg::cmd_t    head_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output rrsf_pkg::result_t result_o
);

  rrsf_pkg::back_phase_t phase_r, phase_nxt;
  rrsf_pkg::back_phase_t eff;
  rrsf_pkg::back_phase_t after;
  rrsf_pkg::result_t     result_r, result_nxt;

  logic out_valid_r, out_valid_nxt;
  logic advance;
  logic fin;
  logic has_r;
  logic has_pad;

  always_comb begin
    advance = !q_empty_i && (!out_valid_r || pop_i);
    has_r   = (head_i.right_len != '0);
    has_pad = (head_i.pad_len != 2'b00);
    eff     = phase_r;
    // a pixel that opens no left fill starts at the pixel itself
    if (phase_r == rrsf_pkg::PH_LEFT && head_i.left_len == '0) begin
      eff = rrsf_pkg::PH_PIXEL;
    end
  end

  // next state
  always_comb begin
    after = rrsf_pkg::PH_LEFT;
    fin   = 1'b1;
    case (eff)
      rrsf_pkg::PH_LEFT: begin
        after = rrsf_pkg::PH_PIXEL;
        fin   = 1'b0;
      end
      rrsf_pkg::PH_PIXEL: begin
        if (has_r) begin
          after = rrsf_pkg::PH_RIGHT;
          fin   = 1'b0;
        end else if (has_pad) begin
          after = rrsf_pkg::PH_PAD;
          fin   = 1'b0;
        end
      end
      rrsf_pkg::PH_RIGHT: begin
        if (has_pad) begin
          after = rrsf_pkg::PH_PAD;
          fin   = 1'b0;
        end
      end
      rrsf_pkg::PH_PAD: fin = 1'b1;
      default: fin = 1'b1;
    endcase
    phase_nxt = phase_r;
    if (advance) begin
      phase_nxt = fin ? rrsf_pkg::PH_LEFT : after;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (pop_i) begin
      out_valid_nxt = 1'b0;
    end
  end

  // outputs
  always_comb begin
    q_pop_o = advance && fin;
    empty_o = !out_valid_r;

    result_nxt.kind       = rrsf_pkg::KIND_FILL;
    result_nxt.blue       = rrsf_pkg::FILL_BYTE;
    result_nxt.green      = rrsf_pkg::FILL_BYTE;
    result_nxt.red        = rrsf_pkg::FILL_BYTE;
    result_nxt.run_length = head_i.left_len;
    result_nxt.row_end    = fin && head_i.row_last;
    result_nxt.last       = fin;
    case (eff)
      rrsf_pkg::PH_LEFT: ;
      rrsf_pkg::PH_PIXEL: begin
        result_nxt.kind       = rrsf_pkg::KIND_PIXEL;
        result_nxt.blue       = head_i.blue;
        result_nxt.green      = head_i.green;
        result_nxt.red        = head_i.red;
        result_nxt.run_length = {{(rrsf_pkg::DIM_W-1){1'b0}}, 1'b1};
      end
      rrsf_pkg::PH_RIGHT: begin
        result_nxt.run_length = head_i.right_len;
      end
      rrsf_pkg::PH_PAD: begin
        result_nxt.kind       = rrsf_pkg::KIND_PAD;
        result_nxt.blue       = 8'h00;
        result_nxt.green      = 8'h00;
        result_nxt.red        = 8'h00;
        result_nxt.run_length = {{(rrsf_pkg::DIM_W-2){1'b0}}, head_i.pad_len};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rrsf_pkg::PH_LEFT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign result_o = result_r;

endmodule

// ===== rtl/core/raster_row_shear_with_fill.sv =====
// a taken pixel enters the command queue, then its first result is registered at the output
// throughput: one pixel per cycle in a row unless the queue is full, one result per cycle at
// the output while popped (1 to 4 results per pixel); the back end sets the sustained rate
// a row's final pixel blocks input while the 14-step divider updates the fill
// reset (rst_n low, synchronous): width 1, height 1, shift 0, queue empty, fill cleared
// ---------------------------------------------------------------------------
// raster_row_shear_with_fill
// Horizontal shear of a 24-bit pixel stream with white fill and row padding.
// ---------------------------------------------------------------------------
module raster_row_shear_with_fill (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     in_blue,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_red,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     out_kind,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_red,
  output logic [rrsf_pkg::DIM_W-1:0]     out_run_length,
  output logic                           out_row_end,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrsf_pkg::DIM_W-1:0]     cfg_data
);

  rrsf_pkg::cmd_t     q_cmd;
  rrsf_pkg::cmd_t     q_head;
  rrsf_pkg::div_req_t div_req;
  rrsf_pkg::div_rsp_t div_rsp;
  rrsf_pkg::result_t  result;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  rrsf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .full_o      (full),
    .blue_i      (in_blue),
    .green_i     (in_green),
    .red_i       (in_red),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  rrsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  rrsf_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  rrsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_i    (q_head),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .result_o  (result)
  );

  assign out_kind       = result.kind;
  assign out_blue       = result.blue;
  assign out_green      = result.green;
  assign out_red        = result.red;
  assign out_run_length = result.run_length;
  assign out_row_end    = result.row_end;
  assign out_last       = result.last;

endmodule
